### src/rrb_pkg.sv
`default_nettype none
package rrb_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned LIMIT_W = 5;
  localparam int unsigned OCC_W   = 5;
  localparam int unsigned CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  typedef enum logic [1:0] {
    FUNC_REQ    = 2'd0,
    FUNC_RETRY  = 2'd1,
    FUNC_RESEND = 2'd2
  } rrb_func_e;

  typedef struct packed {
    rrb_func_e        func;
    logic [TAG_W-1:0] req_tag;
    logic             is_express_snoop;
    logic             needs_response;
    logic             inner_accepts;
  } rrb_in_t;

  typedef struct packed {
    logic             accepted;
    logic             send_attempted;
    logic             send_done;
    logic [TAG_W-1:0] sent_tag;
    logic             retry_upstream;
    logic [OCC_W-1:0] occupancy;
    logic             inner_blocked;
    logic             resend_wanted;
  } rrb_out_t;

  // Write port of the request store.
  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [TAG_W-1:0] wdata;
  } rrb_wr_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### src/rrb_fifo_mem.sv
`default_nettype none
module rrb_fifo_mem
  import rrb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire rrb_wr_t          wr_i,
  input  wire logic [PTR_W-1:0] raddr_i,
  output logic      [TAG_W-1:0] rdata_o
);

  logic [TAG_W-1:0] mem [DEPTH];
  logic [TAG_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.waddr] <= wr_i.wdata;
    end
  end

  // A write to the entry being read shows up in the read data at once.
  always_ff @(posedge clk_i) begin
    if (wr_i.we && (wr_i.waddr == raddr_i)) begin
      rdata_q <= wr_i.wdata;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### src/rrb_ctrl.sv
`default_nettype none
module rrb_ctrl
  import rrb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  wire rrb_in_t            item_i,
  input  wire logic               cfg_we_i,
  input  wire logic [LIMIT_W-1:0] cfg_wdata_i,
  input  wire logic [TAG_W-1:0]   head_data_i,
  output rrb_wr_t                 wr_o,
  output logic      [PTR_W-1:0]   raddr_o,
  output rrb_out_t                res_o
);

  logic [PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               blocked_q, blocked_d;
  logic               owed_q, owed_d;
  logic [LIMIT_W-1:0] limit_q;
  logic               full;
  logic               busy;
  logic               blk;
  logic               push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      blocked_q <= 1'b0;
      owed_q    <= 1'b0;
      limit_q   <= LIMIT_RESET;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      blocked_q <= blocked_d;
      owed_q    <= owed_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // A limit above the depth acts as the depth.
  assign full = (CMP_W'(count_q) >= CMP_W'(DEPTH)) || (CMP_W'(count_q) >= CMP_W'(limit_q));
  assign busy = blocked_q || (count_q != '0);
  assign blk  = (item_i.func == FUNC_RETRY) ? 1'b0 : blocked_q;

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    blocked_d = blocked_q;
    owed_d    = owed_q;
    push      = 1'b0;
    res_o     = '0;
    if (take_i) begin
      case (item_i.func)
        FUNC_REQ: begin
          if (item_i.is_express_snoop) begin
            res_o.send_attempted = 1'b1;
            res_o.send_done      = item_i.inner_accepts;
            res_o.sent_tag       = item_i.req_tag;
            res_o.accepted       = item_i.inner_accepts;
          end else if (!item_i.needs_response) begin
            if (busy) begin
              owed_d = 1'b1;
            end else begin
              res_o.send_attempted = 1'b1;
              res_o.send_done      = item_i.inner_accepts;
              res_o.sent_tag       = item_i.req_tag;
              res_o.accepted       = item_i.inner_accepts;
              if (!item_i.inner_accepts) begin
                blocked_d = 1'b1;
                owed_d    = 1'b1;
              end
            end
          end else begin
            if (!busy) begin
              res_o.send_attempted = 1'b1;
              res_o.send_done      = item_i.inner_accepts;
              res_o.sent_tag       = item_i.req_tag;
            end
            if (!busy && item_i.inner_accepts) begin
              res_o.accepted = 1'b1;
            end else begin
              if (!busy) begin
                blocked_d = 1'b1;
              end
              if (full) begin
                owed_d = 1'b1;
              end else begin
                push           = 1'b1;
                res_o.accepted = 1'b1;
                tail_d         = ptr_inc(tail_q);
                count_d        = count_q + CNT_W'(1);
              end
            end
          end
        end
        FUNC_RETRY, FUNC_RESEND: begin
          blocked_d = blk;
          if ((count_q == '0) && !blk && owed_q) begin
            owed_d               = 1'b0;
            res_o.retry_upstream = 1'b1;
          end else if ((count_q != '0) && !blk) begin
            res_o.send_attempted = 1'b1;
            res_o.send_done      = item_i.inner_accepts;
            res_o.sent_tag       = head_data_i;
            if (!item_i.inner_accepts) begin
              blocked_d = 1'b1;
            end else begin
              head_d  = ptr_inc(head_q);
              count_d = count_q - CNT_W'(1);
              if (count_q != CNT_W'(1)) begin
                res_o.resend_wanted = 1'b1;
              end else if (owed_q) begin
                owed_d               = 1'b0;
                res_o.retry_upstream = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
      res_o.occupancy     = OCC_W'(count_d);
      res_o.inner_blocked = blocked_d;
    end
  end

  assign wr_o.we    = push;
  assign wr_o.waddr = tail_q;
  assign wr_o.wdata = item_i.req_tag;
  assign raddr_o    = head_d;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(DEPTH) >= count_q)
    else $error("held count beyond depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == tail_q) |-> ((count_q == '0) || (count_q == CNT_W'(DEPTH))))
    else $error("pointers and held count disagree");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("push did not raise held count");

  a_retry_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.retry_upstream |-> ((count_d == '0) && !blocked_d))
    else $error("upstream retry while buffer busy");

endmodule
`default_nettype wire

### src/rrb_out_skid.sv
`default_nettype none
module rrb_out_skid
  import rrb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire rrb_out_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  input  wire logic     ready_i,
  output rrb_out_t      data_o
);

  logic     out_valid_q, skid_valid_q;
  rrb_out_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || ready_i) begin
        out_valid_q  <= skid_valid_q || push_i;
        skid_valid_q <= 1'b0;
      end else if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || ready_i) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds an item ahead of the output stage");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("item pushed while both stages are full");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && ready_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid item was not moved to the output stage");

endmodule
`default_nettype wire

### src/request_retry_buffer_unit.sv
// Request retry buffer: flow control between an upstream requester and a
// downstream cache port. Each item on the input channel (in_valid_i /
// in_ready_o / in_item_i) is a new request, a downstream retry or a resend
// tick; each accepted item yields exactly one result item on the output
// channel (out_valid_o / out_ready_i / out_item_o) in the same order.
// Queued request tags live in a 16-entry synchronous memory. The entry at the
// head is always prefetched into the memory's read register, and a write to
// the head entry is forwarded into it, so the decision for an item does not
// wait on a memory read.
// Each result is registered in the output stage before it reaches out_item_o.
// Throughput is one item per cycle while in_ready_o is high, set by the single
// read-modify-write pass over the state registers and the store.
// When the receiver stalls, one more result is held in a skid stage; only
// once both output stages are full does in_ready_o drop.
// The user must write the buffer limit through cfg_we_i / cfg_wdata_i only while
// the block is idle; the block does not enforce this. Reset empties the buffer,
// clears the blocked and retry-owed flags and sets the limit to 16; the memory
// is not cleared, and no entry's data is used before it is written.
`default_nettype none
module request_retry_buffer_unit
  import rrb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire rrb_in_t            in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output rrb_out_t                out_item_o,
  input  wire logic               cfg_we_i,
  input  wire logic [LIMIT_W-1:0] cfg_wdata_i
);

  logic             take;
  rrb_wr_t          wr;
  logic [PTR_W-1:0] raddr;
  logic [TAG_W-1:0] head_data;
  rrb_out_t         res;

  // An item is taken whenever the skid stage has room.
  assign take = in_valid_i && in_ready_o;

  rrb_fifo_mem u_mem (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (head_data)
  );

  rrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .item_i      (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_data_i (head_data),
    .wr_o        (wr),
    .raddr_o     (raddr),
    .res_o       (res)
  );

  rrb_out_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .data_i  (res),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_item_o)
  );

endmodule
`default_nettype wire
